@@ design/chained_range_remap_min_macros.svh @@
// Assertion helpers shared by the remap block.
`ifndef CHAINED_RANGE_REMAP_MIN_MACROS_SVH
`define CHAINED_RANGE_REMAP_MIN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("remap block check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("remap block check failed");

`endif

@@ design/crm_pkg.sv @@
`timescale 1ns / 1ps

package crm_pkg;

  // Chain geometry.
  localparam int STAGES  = 7;
  localparam int ENTRIES = 64;
  localparam int TOTAL   = STAGES * ENTRIES;

  // Field and index widths.
  localparam int VAL_W   = 63;
  localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  // One table word: valid bit, source base, destination base, span.
  localparam int WORD_W  = 1 + 3 * VAL_W;

  // Request operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Sequencer state codes.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Outcome of testing one table entry against the current value.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } match_t;

endpackage

@@ design/crm_ram.sv @@
`timescale 1ns / 1ps

module crm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/crm_match.sv @@
`timescale 1ns / 1ps

module crm_match (
  input  logic [crm_pkg::WORD_W-1:0] word,
  input  logic [crm_pkg::VAL_W-1:0]  value,
  output crm_pkg::match_t            result
);

  logic                      ent_valid;
  logic [crm_pkg::VAL_W-1:0] ent_src;
  logic [crm_pkg::VAL_W-1:0] ent_dst;
  logic [crm_pkg::VAL_W-1:0] ent_span;
  logic [crm_pkg::VAL_W:0]   diff_ext;
  logic [crm_pkg::VAL_W-1:0] offset;

  assign {ent_valid, ent_src, ent_dst, ent_span} = word;

  // Offset into the window; the extra top bit is the borrow (value below source).
  assign diff_ext = {1'b0, value} - {1'b0, ent_src};
  assign offset   = diff_ext[crm_pkg::VAL_W-1:0];

  // The window end is never formed, so a window past the top covers every value from source up.
  assign result.hit   = ent_valid && !diff_ext[crm_pkg::VAL_W] && (offset < ent_span);
  assign result.value = ent_dst + offset;

endmodule

@@ design/chained_range_remap_min.sv @@
`timescale 1ns / 1ps
// Chained range remap with running minimum.
// Requests enter on the in_ ports and are taken at a clock edge where start is high and
// busy is low. A write request loads one slot of one stage table and a clear request
// resets the running minimum; busy stays low for both. A map request walks the slots of
// each stage in order until one matches and then goes on to the next stage, one table
// read per cycle except for a bubble after each hit that skips slots, through a single
// shared window compare and adder, and produces one result on out_mapped_value and
// out_running_minimum, marked by a one-cycle out_valid strobe. A hit in the last stage,
// or the last slot of the last stage, ends the walk; each matching slot that is not the
// last of its stage skips the rest of that stage. The single read port of the table
// memory sets the pace of the walk. busy stays high until the strobe cycle, so the next
// request can be taken at the edge that ends the strobe.
// After reset a clearing pass writes every table word invalid with busy high; the
// running minimum resets to all ones. The receiver cannot stall: each result is shown
// for exactly one cycle.

`include "chained_range_remap_min_macros.svh"

module chained_range_remap_min (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [2:0]                  in_stage_index,
  input  logic [5:0]                  in_slot_index,
  input  logic [crm_pkg::VAL_W-1:0]   in_entry_source,
  input  logic [crm_pkg::VAL_W-1:0]   in_entry_dest,
  input  logic [crm_pkg::VAL_W-1:0]   in_entry_span,
  input  logic                        in_entry_valid,
  input  logic [crm_pkg::VAL_W-1:0]   in_query_value,
  output logic                        out_valid,
  output logic [crm_pkg::VAL_W-1:0]   out_mapped_value,
  output logic [crm_pkg::VAL_W-1:0]   out_running_minimum
);

  localparam int AW = crm_pkg::ADDR_W;
  localparam int SW = crm_pkg::SLOT_W;
  localparam int GW = crm_pkg::STAGE_W;
  localparam int VW = crm_pkg::VAL_W;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          iss_act_r, iss_act_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [GW-1:0] stage_r, stage_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_base_r, rd_base_nxt;
  logic [SW-1:0] rd_slot_r, rd_slot_nxt;
  logic [GW-1:0] rd_stage_r, rd_stage_nxt;
  logic [VW-1:0] value_r, value_nxt;
  logic [VW-1:0] min_r, min_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_mapped_r, out_mapped_nxt;
  logic [VW-1:0] out_min_r, out_min_nxt;

  logic                        accept;
  logic                        wr_in_range;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [crm_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [crm_pkg::WORD_W-1:0]  ram_rdata;
  logic [AW-1:0]               wr_addr;
  crm_pkg::match_t             mres;
  logic                        slot_last, stage_last;
  logic                        rd_slot_last, rd_stage_last;
  logic                        ev_hit, ev_jump, ev_fin;

  assign busy   = (state_r != crm_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Write requests outside the chain geometry are dropped.
  assign wr_in_range = (32'(in_stage_index) < crm_pkg::STAGES) &&
                       (32'(in_slot_index) < crm_pkg::ENTRIES);
  assign wr_addr     = AW'(32'(in_stage_index) * crm_pkg::ENTRIES + 32'(in_slot_index));

  // Table write port: the clearing pass owns it until the block goes idle.
  always_comb begin
    if (state_r == crm_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && (in_operation == crm_pkg::OP_WRITE) && wr_in_range;
      ram_waddr = wr_addr;
      ram_wdata = {in_entry_valid, in_entry_source, in_entry_dest, in_entry_span};
    end
  end

  assign ram_raddr = base_r + AW'(slot_r);

  crm_ram #(
    .WIDTH (crm_pkg::WORD_W),
    .DEPTH (crm_pkg::TOTAL)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared window test and remap adder.
  crm_match u_match (
    .word   (ram_rdata),
    .value  (value_r),
    .result (mres)
  );

  assign slot_last     = (slot_r == SW'(crm_pkg::ENTRIES - 1));
  assign stage_last    = (stage_r == GW'(crm_pkg::STAGES - 1));
  assign rd_slot_last  = (rd_slot_r == SW'(crm_pkg::ENTRIES - 1));
  assign rd_stage_last = (rd_stage_r == GW'(crm_pkg::STAGES - 1));

  // A hit ends the current stage; one in the last stage, or the final slot, ends the walk.
  assign ev_hit  = rd_vld_r && mres.hit;
  assign ev_jump = ev_hit && !rd_stage_last && !rd_slot_last;
  assign ev_fin  = rd_vld_r && rd_stage_last && (mres.hit || rd_slot_last);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    iss_act_nxt    = iss_act_r;
    base_nxt       = base_r;
    slot_nxt       = slot_r;
    stage_nxt      = stage_r;
    rd_vld_nxt     = 1'b0;
    rd_base_nxt    = rd_base_r;
    rd_slot_nxt    = rd_slot_r;
    rd_stage_nxt   = rd_stage_r;
    value_nxt      = value_r;
    min_nxt        = min_r;
    out_mapped_nxt = out_mapped_r;
    out_min_nxt    = out_min_r;
    out_valid_nxt  = (state_r == crm_pkg::ST_DONE);

    case (state_r)
      crm_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(crm_pkg::TOTAL - 1)) begin
          state_nxt = crm_pkg::ST_IDLE;
        end
      end
      crm_pkg::ST_IDLE: begin
        if (accept && (in_operation == crm_pkg::OP_MAP)) begin
          value_nxt   = in_query_value;
          base_nxt    = '0;
          slot_nxt    = '0;
          stage_nxt   = '0;
          iss_act_nxt = 1'b1;
          state_nxt   = crm_pkg::ST_RUN;
        end else if (accept && (in_operation == crm_pkg::OP_CLEAR)) begin
          min_nxt = '1;
        end
      end
      crm_pkg::ST_RUN: begin
        // Issue the next table read and step the slot pointer.
        if (iss_act_r) begin
          rd_vld_nxt   = 1'b1;
          rd_base_nxt  = base_r;
          rd_slot_nxt  = slot_r;
          rd_stage_nxt = stage_r;
          if (slot_last) begin
            if (stage_last) begin
              iss_act_nxt = 1'b0;
            end else begin
              slot_nxt  = '0;
              stage_nxt = stage_r + GW'(1);
              base_nxt  = base_r + AW'(crm_pkg::ENTRIES);
            end
          end else begin
            slot_nxt = slot_r + SW'(1);
          end
        end
        // Evaluate the word that came back this cycle.
        if (ev_hit) begin
          value_nxt = mres.value;
        end
        if (ev_jump) begin
          rd_vld_nxt  = 1'b0;
          slot_nxt    = '0;
          stage_nxt   = rd_stage_r + GW'(1);
          base_nxt    = rd_base_r + AW'(crm_pkg::ENTRIES);
          iss_act_nxt = 1'b1;
        end
        if (ev_fin) begin
          rd_vld_nxt  = 1'b0;
          iss_act_nxt = 1'b0;
          state_nxt   = crm_pkg::ST_DONE;
        end
      end
      crm_pkg::ST_DONE: begin
        out_mapped_nxt = value_r;
        if (value_r < min_r) begin
          min_nxt     = value_r;
          out_min_nxt = value_r;
        end else begin
          out_min_nxt = min_r;
        end
        state_nxt = crm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = crm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crm_pkg::ST_CLEAR;
      clr_r       <= '0;
      iss_act_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_act_r   <= iss_act_nxt;
      rd_vld_r    <= rd_vld_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    slot_r       <= slot_nxt;
    stage_r      <= stage_nxt;
    rd_base_r    <= rd_base_nxt;
    rd_slot_r    <= rd_slot_nxt;
    rd_stage_r   <= rd_stage_nxt;
    value_r      <= value_nxt;
    out_mapped_r <= out_mapped_nxt;
    out_min_r    <= out_min_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_mapped_value    = out_mapped_r;
  assign out_running_minimum = out_min_r;

  // Checks on the sequencer and result path.
  `CRM_ASSERT_NEXT(a_done_gives_strobe, clk, rst_n, state_r == crm_pkg::ST_DONE, out_valid)
  `CRM_ASSERT_SAME(a_min_not_above, clk, rst_n, out_valid, out_running_minimum <= out_mapped_value)
  `CRM_ASSERT_SAME(a_idle_no_reads, clk, rst_n, state_r == crm_pkg::ST_IDLE, !rd_vld_r && !iss_act_r)
  `CRM_ASSERT_SAME(a_clear_is_busy, clk, rst_n, state_r == crm_pkg::ST_CLEAR, busy && ram_we)

endmodule
